>>> sv/cns_pkg.sv
// cns_pkg: shared constants, codes and coefficient tables for the colored noise shaper
// depends on nothing; imported by colored_noise_shaper
`timescale 1ns / 1ps
`default_nettype none

package cns_pkg;

    localparam int STATE_FRAC_BITS_DEF = 24;
    localparam int DATA_W              = 16;
    localparam int MODE_W              = 2;
    localparam int VOL_W               = 17;
    localparam int APB_DW              = 32;
    localparam int APB_AW              = 3;
    localparam int COEF_W              = 32;
    localparam int COEF_FRAC           = 30;
    localparam int DIGIT_W             = 32;

    localparam logic [VOL_W-1:0] VOL_RESET = 17'd19661;
    localparam logic [VOL_W-1:0] VOL_MAX   = 17'd65536;

    // register index, taken from paddr[2]
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_VOLUME = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WHITE = 2'd0,
        MODE_PINK  = 2'd1,
        MODE_BROWN = 2'd2,
        MODE_MUTE  = 2'd3
    } mode_t;

    // operand source of the shared multiplier
    typedef enum logic [2:0] {
        X_SEC,
        X_WF,
        X_SUM,
        X_Y,
        X_ACC
    } x_sel_t;

    // what happens with the rounded product
    typedef enum logic [2:0] {
        ACT_TMP,
        ACT_SEC,
        ACT_DIR,
        ACT_DLY,
        ACT_Y,
        ACT_BRN,
        ACT_V
    } act_t;

    typedef struct packed {
        x_sel_t              x_sel;
        logic [COEF_W-1:0]   coef_mag;
        logic                coef_neg;
        act_t                act;
    } op_ctl_t;

    // coefficient magnitudes, Q2.30
    localparam logic [COEF_W-1:0] COEF_DIRECT     = 32'd575740366;
    localparam logic [COEF_W-1:0] COEF_DELAY      = 32'd124474595;
    localparam logic [COEF_W-1:0] COEF_PINK_GAIN  = 32'd118111601;
    localparam logic [COEF_W-1:0] COEF_LEAK       = 32'd1070520599;
    localparam logic [COEF_W-1:0] COEF_BROWN_IN   = 32'd21474836;
    localparam logic [COEF_W-1:0] COEF_BROWN_GAIN = 32'd3758096384;

    localparam int PINK_SECTIONS = 6;

    function automatic logic [COEF_W-1:0] pole_mag(input logic [2:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            3'd0:    c = 32'd1072517758;
            3'd1:    c = 32'd1066569229;
            3'd2:    c = 32'd1040455827;
            3'd3:    c = 32'd930397290;
            3'd4:    c = 32'd590558003;
            3'd5:    c = 32'd817761773;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] feed_mag(input logic [2:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            3'd0:    c = 32'd59611891;
            3'd1:    c = 32'd80612134;
            3'd2:    c = 32'd165197327;
            3'd3:    c = 32'd333381374;
            3'd4:    c = 32'd572253067;
            3'd5:    c = 32'd18144089;
            default: c = '0;
        endcase
        return c;
    endfunction

    // the last section has negative pole and feed coefficients
    function automatic logic coef_is_neg(input logic [2:0] idx);
        return (idx == 3'd5);
    endfunction

endpackage

`default_nettype wire

>>> sv/colored_noise_shaper.sv
// colored_noise_shaper: white, pink (six-section filter) or brown noise shaping with volume
// depends on cns_pkg; one shared digit-serial multiplier under a small sequencer
`timescale 1ns / 1ps
`default_nettype none

// per item: N products (pink 16, brown 4, white 1, mute 0), each a load, ND digit passes
//   through the 32x32 multiplier, a round and an apply, ND = ceil((STATE_FRAC_BITS+11)/32);
//   then the output scale and round steps before the sample reaches m_tvalid
// s_tready is low while an item is in work and while a finished sample waits for the
//   output register to free up
// reset: synchronous, active low; clears filter state, mode (white) and volume (19661)
module colored_noise_shaper #(
    parameter int STATE_FRAC_BITS = cns_pkg::STATE_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cns_pkg::DATA_W-1:0]  s_tdata,   // [15:0] white_sample
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cns_pkg::DATA_W-1:0]  m_tdata,   // [15:0] audio_sample
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cns_pkg::APB_AW-1:0]  paddr,
    input  logic [cns_pkg::APB_DW-1:0]  pwdata,
    output logic [cns_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import cns_pkg::*;

    localparam int F   = STATE_FRAC_BITS;
    localparam int SW  = F + 8;                        // filter state, 8 integer bits
    localparam int XW  = F + 11;                       // sums and products
    localparam int ND  = (XW + DIGIT_W - 1) / DIGIT_W; // digit passes per product
    localparam int UXW = ND * DIGIT_W;
    localparam int PW  = UXW + COEF_W;                 // full product width
    localparam int MW  = F + 1;                        // clamped output magnitude
    localparam int PSW = F + 16;                       // magnitude times 32767
    localparam int DCW = (ND > 1) ? $clog2(ND) : 1;

    localparam logic signed [XW-1:0] ST_MAX = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [XW-1:0] ST_MIN = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [XW-1:0] V_MAX  = {{(XW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [XW-1:0] V_MIN  = {{(XW-F){1'b1}}, {F{1'b0}}};
    localparam logic [PW-1:0]        RND_HALF = PW'(1) << (COEF_FRAC - 1);
    localparam logic [F-1:0]         OUT_HALF = {1'b1, {(F-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_RND,
        ST_APPLY,
        ST_SCALE,
        ST_ROUND
    } state_t;

    // control and state registers
    state_t                 state_reg;
    logic [3:0]             op_reg;
    logic [DCW-1:0]         dig_reg;
    logic                   m_tvalid_reg;
    logic [DATA_W-1:0]      m_tdata_reg;
    mode_t                  mode_reg;
    logic [VOL_W-1:0]       vol_reg;
    logic signed [SW-1:0]   sec_reg [PINK_SECTIONS];
    logic signed [SW-1:0]   dly_reg;
    logic signed [SW-1:0]   brn_reg;

    // datapath registers
    logic [UXW-1:0]         ux_reg;
    logic [COEF_W-1:0]      uc_reg;
    logic                   neg_reg;
    logic [PW-1:0]          acc_reg;
    logic signed [XW-1:0]   q_reg;
    logic signed [XW-1:0]   wf_reg;
    logic signed [XW-1:0]   tmp_reg;
    logic signed [XW-1:0]   sum_reg;
    logic signed [XW-1:0]   y_reg;
    logic signed [XW-1:0]   v_reg;
    logic [PSW-1:0]         p_reg;
    logic                   pneg_reg;

    // combinational helpers
    op_ctl_t                ctl;
    logic [2:0]             sec_idx;
    logic signed [SW-1:0]   sec_rd;
    logic signed [XW-1:0]   x_op;
    logic [XW-1:0]          x_abs;
    logic signed [XW-1:0]   wf_in;
    logic [2*DIGIT_W:0]     digit_prod;
    logic [PW-1:0]          acc_next;
    logic [PW-1:0]          rnd_sum;
    logic [XW-1:0]          q_mag;
    logic signed [XW-1:0]   tmp_plus_q;
    logic signed [SW-1:0]   tmp_plus_q_sat;
    logic signed [XW-1:0]   v_clamp;
    logic [XW-1:0]          v_abs;
    logic [MW-1:0]          v_mag;
    logic [DATA_W-1:0]      out_q;
    logic [F-1:0]           out_r;
    logic                   out_up;
    logic [DATA_W-1:0]      out_qr;
    logic [DATA_W-1:0]      out_s;
    logic                   in_beat;
    logic                   cfg_wr;
    logic                   out_free;
    logic                   out_load;
    logic [VOL_W-1:0]       vol_wdata;

    function automatic logic signed [SW-1:0] sat_state(input logic signed [XW-1:0] a);
        logic signed [SW-1:0] r;
        if (a > ST_MAX) begin
            r = ST_MAX[SW-1:0];
        end else if (a < ST_MIN) begin
            r = ST_MIN[SW-1:0];
        end else begin
            r = a[SW-1:0];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_ROUND) && out_free;

    // register port: writes land on psel & penable & pwrite, no wait states
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign vol_wdata = (pwdata[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : pwdata[VOL_W-1:0];

    always_comb begin
        unique case (paddr[2])
            REG_MODE:   prdata = {{(APB_DW-MODE_W){1'b0}}, mode_reg};
            REG_VOLUME: prdata = {{(APB_DW-VOL_W){1'b0}}, vol_reg};
            default:    prdata = '0;
        endcase
    end

    // white sample as a state-format value
    assign wf_in = {{(XW-1-F){s_tdata[DATA_W-1]}}, s_tdata, {(F-15){1'b0}}};

    // op decode: pink alternates pole and feed products per section, then the direct
    // term, the delayed term, the 0.11 gain and the volume; brown is leak, input,
    // 3.5 gain and volume; white only needs the volume product
    assign sec_idx = op_reg[3:1];

    always_comb begin
        ctl.x_sel    = X_Y;
        ctl.coef_mag = {1'b0, vol_reg, 14'b0};
        ctl.coef_neg = 1'b0;
        ctl.act      = ACT_V;
        unique case (mode_reg)
            MODE_PINK: begin
                if (op_reg < 4'd12) begin
                    ctl.coef_neg = coef_is_neg(sec_idx);
                    if (!op_reg[0]) begin
                        ctl.x_sel    = X_SEC;
                        ctl.coef_mag = pole_mag(sec_idx);
                        ctl.act      = ACT_TMP;
                    end else begin
                        ctl.x_sel    = X_WF;
                        ctl.coef_mag = feed_mag(sec_idx);
                        ctl.act      = ACT_SEC;
                    end
                end else begin
                    case (op_reg[1:0])
                        2'd0: begin
                            ctl.x_sel    = X_WF;
                            ctl.coef_mag = COEF_DIRECT;
                            ctl.act      = ACT_DIR;
                        end
                        2'd1: begin
                            ctl.x_sel    = X_WF;
                            ctl.coef_mag = COEF_DELAY;
                            ctl.act      = ACT_DLY;
                        end
                        2'd2: begin
                            ctl.x_sel    = X_SUM;
                            ctl.coef_mag = COEF_PINK_GAIN;
                            ctl.act      = ACT_Y;
                        end
                        default: begin
                            ctl.x_sel    = X_Y;
                            ctl.coef_mag = {1'b0, vol_reg, 14'b0};
                            ctl.act      = ACT_V;
                        end
                    endcase
                end
            end
            MODE_BROWN: begin
                case (op_reg[1:0])
                    2'd0: begin
                        ctl.x_sel    = X_ACC;
                        ctl.coef_mag = COEF_LEAK;
                        ctl.act      = ACT_TMP;
                    end
                    2'd1: begin
                        ctl.x_sel    = X_WF;
                        ctl.coef_mag = COEF_BROWN_IN;
                        ctl.act      = ACT_BRN;
                    end
                    2'd2: begin
                        ctl.x_sel    = X_ACC;
                        ctl.coef_mag = COEF_BROWN_GAIN;
                        ctl.act      = ACT_Y;
                    end
                    default: begin
                        ctl.x_sel    = X_Y;
                        ctl.coef_mag = {1'b0, vol_reg, 14'b0};
                        ctl.act      = ACT_V;
                    end
                endcase
            end
            default: begin
                ctl.x_sel    = X_Y;
                ctl.coef_mag = {1'b0, vol_reg, 14'b0};
                ctl.act      = ACT_V;
            end
        endcase
    end

    // operand select
    assign sec_rd = (sec_idx < 3'(PINK_SECTIONS)) ? sec_reg[sec_idx] : '0;

    always_comb begin
        case (ctl.x_sel)
            X_SEC:   x_op = {{(XW-SW){sec_rd[SW-1]}}, sec_rd};
            X_WF:    x_op = wf_reg;
            X_SUM:   x_op = sum_reg;
            X_ACC:   x_op = {{(XW-SW){brn_reg[SW-1]}}, brn_reg};
            default: x_op = y_reg;
        endcase
    end

    assign x_abs = x_op[XW-1] ? (~x_op + XW'(1)) : x_op;

    // one digit pass: shift the partial product up and add the next digit times coef
    assign digit_prod = (2*DIGIT_W+1)'(ux_reg[UXW-1 -: DIGIT_W] * uc_reg);
    assign acc_next   = (acc_reg << DIGIT_W) + PW'(digit_prod);

    // round the magnitude half up, so ties go away from zero after the sign
    assign rnd_sum = acc_reg + RND_HALF;
    assign q_mag   = rnd_sum[COEF_FRAC +: XW];

    assign tmp_plus_q     = tmp_reg + q_reg;
    assign tmp_plus_q_sat = sat_state(tmp_plus_q);

    assign v_clamp = (q_reg > V_MAX) ? V_MAX : ((q_reg < V_MIN) ? V_MIN : q_reg);

    // output scaling: |v| * 32767 as a shift and subtract
    assign v_abs = v_reg[XW-1] ? (~v_reg + XW'(1)) : v_reg;
    assign v_mag = v_abs[MW-1:0];

    // round to nearest, ties to even
    assign out_q  = p_reg[PSW-1:F];
    assign out_r  = p_reg[F-1:0];
    assign out_up = (out_r > OUT_HALF) || ((out_r == OUT_HALF) && out_q[0]);
    assign out_qr = out_q + DATA_W'(out_up);
    assign out_s  = pneg_reg ? (~out_qr + DATA_W'(1)) : out_qr;

    // sequencer, filter state and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            dig_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= MODE_WHITE;
            vol_reg      <= VOL_RESET;
            for (int i = 0; i < PINK_SECTIONS; i++) begin
                sec_reg[i] <= '0;
            end
            dly_reg      <= '0;
            brn_reg      <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_VOLUME) begin
                    vol_reg <= vol_wdata;
                end else begin
                    mode_reg <= mode_t'(pwdata[MODE_W-1:0]);
                end
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        op_reg <= '0;
                        // mute skips all products and emits zero
                        state_reg <= (mode_reg == MODE_MUTE) ? ST_SCALE : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    dig_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    dig_reg <= dig_reg + DCW'(1);
                    if (dig_reg == DCW'(ND - 1)) begin
                        state_reg <= ST_RND;
                    end
                end
                ST_RND: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    case (ctl.act)
                        ACT_SEC: sec_reg[sec_idx] <= tmp_plus_q_sat;
                        ACT_DLY: dly_reg          <= sat_state(q_reg);
                        ACT_BRN: brn_reg          <= tmp_plus_q_sat;
                        default: ;
                    endcase
                    op_reg    <= op_reg + 4'd1;
                    state_reg <= (ctl.act == ACT_V) ? ST_SCALE : ST_LOAD;
                end
                ST_SCALE: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    // hold here until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= out_s;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    wf_reg  <= wf_in;
                    y_reg   <= wf_in;
                    sum_reg <= '0;
                    v_reg   <= '0;
                end
            end
            ST_LOAD: begin
                ux_reg  <= {{(UXW-XW){1'b0}}, x_abs};
                uc_reg  <= ctl.coef_mag;
                neg_reg <= x_op[XW-1] ^ ctl.coef_neg;
                acc_reg <= '0;
            end
            ST_MUL: begin
                acc_reg <= acc_next;
                ux_reg  <= ux_reg << DIGIT_W;
            end
            ST_RND: begin
                q_reg <= neg_reg ? (~q_mag + XW'(1)) : q_mag;
            end
            ST_APPLY: begin
                case (ctl.act)
                    ACT_TMP: tmp_reg <= q_reg;
                    ACT_SEC: sum_reg <= sum_reg + {{(XW-SW){tmp_plus_q_sat[SW-1]}},
                                                   tmp_plus_q_sat};
                    ACT_DIR: sum_reg <= sum_reg + {{(XW-SW){dly_reg[SW-1]}}, dly_reg}
                                        + q_reg;
                    ACT_Y:   y_reg   <= q_reg;
                    ACT_V:   v_reg   <= v_clamp;
                    default: ;
                endcase
            end
            ST_SCALE: begin
                p_reg    <= {v_mag, 15'b0} - PSW'(v_mag);
                pneg_reg <= v_reg[XW-1];
            end
            ST_ROUND: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/cns_checker.sv
// cns_checker: port-level checks of the colored noise shaper stream behavior
// depends on nothing; bound to colored_noise_shaper at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module cns_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled output beat keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // an accepted input beat keeps the block busy in the next cycle
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an input beat");

    // saturation keeps the output inside the symmetric range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("output sample outside symmetric range");

    // reset leaves no output beat pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind colored_noise_shaper cns_checker u_cns_checker (.*);

`default_nettype wire

>>> bench/shaper_checker.sv
// shaper_checker: watches the register port and both streams of colored_noise_shaper,
// predicts every pcm beat and compares it; depends on cns_pkg
`timescale 1ns / 1ps

module shaper_checker #(
    parameter int FRAC_BITS = cns_pkg::STATE_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [cns_pkg::DATA_W-1:0]  s_tdata,   // [15:0] white_sample
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [cns_pkg::DATA_W-1:0]  m_tdata,   // [15:0] audio_sample
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cns_pkg::APB_AW-1:0]  paddr,
    input  logic [cns_pkg::APB_DW-1:0]  pwdata,
    input  logic                        pready,
    output int                          pcm_pending,
    output int                          fail_count
);
    import cns_pkg::*;

    mode_t              shape_mode;
    logic [VOL_W-1:0]   gain;
    longint             pink_sec [PINK_SECTIONS];
    longint             pink_dly;
    longint             brown_acc;
    longint             pole_k [PINK_SECTIONS];
    longint             feed_k [PINK_SECTIONS];
    longint             k_direct, k_delay, k_pink_gain, k_leak, k_brown_in, k_brown_gain;
    logic [DATA_W-1:0]  expected_pcm [$];
    logic [DATA_W-1:0]  want;
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic longint coef_q30(input longint num, input longint den);
        return ((num <<< 30) + den / 2) / den;
    endfunction

    initial begin
        pole_k[0] = coef_q30(99886, 100000);
        pole_k[1] = coef_q30(99332, 100000);
        pole_k[2] = coef_q30(969, 1000);
        pole_k[3] = coef_q30(8665, 10000);
        pole_k[4] = coef_q30(55, 100);
        pole_k[5] = -coef_q30(7616, 10000);
        feed_k[0] = coef_q30(555179, 10000000);
        feed_k[1] = coef_q30(750759, 10000000);
        feed_k[2] = coef_q30(153852, 1000000);
        feed_k[3] = coef_q30(3104856, 10000000);
        feed_k[4] = coef_q30(5329522, 10000000);
        feed_k[5] = -coef_q30(168980, 10000000);
        k_direct     = coef_q30(5362, 10000);
        k_delay      = coef_q30(115926, 1000000);
        k_pink_gain  = coef_q30(11, 100);
        k_leak       = coef_q30(997, 1000);
        k_brown_in   = coef_q30(2, 100);
        k_brown_gain = coef_q30(35, 10);
    end

    // x * c / 2^30, rounded to nearest with ties away from zero
    function automatic longint round_mul(input longint x, input longint c);
        logic [127:0] prod;
        logic [63:0]  mx, mc;
        mx = (x < 0) ? -x : x;
        mc = (c < 0) ? -c : c;
        prod = {64'd0, mx} * {64'd0, mc};
        prod = (prod + (128'd1 << 29)) >> 30;
        return ((x < 0) != (c < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // filter state holds 8 integer bits
    function automatic longint clamp_state(input longint v);
        longint hi;
        hi = (longint'(1) <<< (FRAC_BITS + 7)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // one white sample in, one pcm sample out; advances the selected filter
    function automatic logic [DATA_W-1:0] shape_sample(input logic signed [DATA_W-1:0] w);
        longint      wf, y, v, sum, lim;
        logic [63:0] mag, q, r, half;
        int          i;
        wf = longint'(w) <<< (FRAC_BITS - 15);
        case (shape_mode)
            MODE_WHITE: y = wf;
            MODE_PINK: begin
                sum = 0;
                for (i = 0; i < PINK_SECTIONS; i++) begin
                    pink_sec[i] = clamp_state(round_mul(pink_sec[i], pole_k[i])
                                              + round_mul(wf, feed_k[i]));
                    sum += pink_sec[i];
                end
                sum += pink_dly + round_mul(wf, k_direct);
                pink_dly = clamp_state(round_mul(wf, k_delay));
                y = round_mul(sum, k_pink_gain);
            end
            MODE_BROWN: begin
                brown_acc = clamp_state(round_mul(brown_acc, k_leak)
                                        + round_mul(wf, k_brown_in));
                y = round_mul(brown_acc, k_brown_gain);
            end
            default: return '0;   // unused mode: silence, no state change
        endcase
        v = round_mul(y, longint'(gain) <<< 14);
        lim = longint'(1) <<< FRAC_BITS;
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        // scale by 32767, round half to even
        mag = (v < 0) ? -v : v;
        mag = mag * 64'd32767;
        q = mag >> FRAC_BITS;
        r = mag & ((64'd1 << FRAC_BITS) - 1);
        half = 64'd1 << (FRAC_BITS - 1);
        if (r > half || (r == half && q[0]))
            q = q + 1;
        if (v < 0)
            q = -q;
        return q[DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode = MODE_WHITE;
            gain = VOL_RESET;
            for (int i = 0; i < PINK_SECTIONS; i++)
                pink_sec[i] = 0;
            pink_dly = 0;
            brown_acc = 0;
            expected_pcm.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MODE) begin
                    shape_mode = mode_t'(pwdata[MODE_W-1:0]);
                end else if (pwdata[VOL_W-1:0] > VOL_MAX) begin
                    gain = VOL_MAX;
                end else begin
                    gain = pwdata[VOL_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_pcm.size() == 0) begin
                    report_mismatch($sformatf("unexpected pcm beat, audio_sample %0d",
                                              $signed(m_tdata)));
                end else begin
                    want = expected_pcm.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("audio_sample got %0d, want %0d",
                                                  $signed(m_tdata), $signed(want)));
                end
            end
            if (s_tvalid && s_tready)
                expected_pcm.push_back(shape_sample($signed(s_tdata)));
        end
        pcm_pending <= expected_pcm.size();
    end

endmodule

>>> bench/tb_top.sv
// tb_top: stimulus and verdict for colored_noise_shaper
// depends on cns_pkg, colored_noise_shaper and shaper_checker (prediction and compare)
`timescale 1ns / 1ps

module tb_top;
    import cns_pkg::*;

    localparam int FRAC_BITS     = STATE_FRAC_BITS_DEF;
    localparam int QUIET_LIMIT   = 2000;   // cycles with no beat and no register access
    localparam int DRAIN_CYCLES  = 100;    // covers the longest item (pink)
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;

    localparam logic [APB_AW-1:0] ADDR_MODE   = {REG_MODE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_VOLUME = {REG_VOLUME, 2'b00};

    localparam logic [DATA_W-1:0] W_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] W_MIN = 16'h8000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata  = '0;   // [15:0] white_sample
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;         // [15:0] audio_sample
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [APB_AW-1:0]  paddr    = '0;
    logic [APB_DW-1:0]  pwdata   = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 pcm_pending;
    int                 fail_count;
    bit                 calm = 1'b0;     // no idling on either side while set
    int                 stall_left = 0;
    int                 quiet_cycles = 0;
    int                 hold_left = 0;
    logic [DATA_W-1:0]  held_sample = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    colored_noise_shaper #(
        .STATE_FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    shaper_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .pcm_pending (pcm_pending),
        .fail_count  (fail_count)
    );

    // receiver back-pressure: random stall bursts, none started while calm
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: any beat or register access restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one white sample beat; the sender may idle for a burst first
    task automatic push_sample(input logic [DATA_W-1:0] w);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender off until every expected pcm beat is back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pcm_pending != 0);
    endtask

    // setup, then access, then idle with psel low, so writes can follow back to back
    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // registers only change with the block idle
    task automatic apply_setting(input mode_t mode, input logic [VOL_W-1:0] vol);
        settle();
        reg_write(ADDR_MODE, APB_DW'(mode));
        reg_write(ADDR_VOLUME, APB_DW'(vol));
    endtask

    // mostly full-range noise, some extremes, and now and then a run of one value
    // long enough to push the brown integrator into output saturation
    function automatic logic [DATA_W-1:0] next_white();
        if (hold_left == 0 && $urandom_range(0, 31) == 0) begin
            hold_left = $urandom_range(8, 64);
            if ($urandom_range(0, 3) == 0)
                held_sample = DATA_W'($urandom);
            else
                held_sample = $urandom_range(0, 1) ? W_MAX : W_MIN;
        end
        if (hold_left > 0) begin
            hold_left--;
            return held_sample;
        end
        case ($urandom_range(0, 15))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial begin
        mode_t             mode;
        logic [VOL_W-1:0]  vol;
        int                p;
        int                n;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: white at the default volume
        push_sample(W_MAX);
        push_sample(W_MIN);

        // white at unity gain, field extremes and around zero
        apply_setting(MODE_WHITE, VOL_MAX);
        push_sample(W_MAX);
        push_sample(W_MIN);
        push_sample('0);
        push_sample('1);
        push_sample(16'h0001);

        // unused mode gives silence
        apply_setting(MODE_MUTE, VOL_MAX);
        push_sample(W_MAX);
        push_sample(W_MIN);

        // pink with a volume above unity, which must clip to unity
        apply_setting(MODE_PINK, 17'h1FFFF);
        repeat (4) push_sample(W_MAX);
        repeat (2) push_sample(W_MIN);

        // brown at unity gain
        apply_setting(MODE_BROWN, VOL_MAX);
        repeat (4) push_sample(W_MAX);
        repeat (2) push_sample(W_MIN);

        // zero volume
        apply_setting(MODE_BROWN, '0);
        push_sample(W_MAX);

        // random phases; filter state carries across phases of the same color
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    mode = MODE_PINK;
                    vol = VOL_MAX;
                end
                1: begin
                    mode = MODE_BROWN;
                    vol = 17'h1FFFF;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        mode = MODE_MUTE;
                    else
                        mode = mode_t'($urandom_range(0, 2));
                    case ($urandom_range(0, 7))
                        0:       vol = '0;
                        1:       vol = VOL_MAX;
                        2:       vol = VOL_W'($urandom);   // any 17-bit value, may exceed unity
                        default: vol = VOL_W'($urandom_range(0, 65536));
                    endcase
                end
            endcase
            apply_setting(mode, vol);
            // one stretch mid-run and the final stretch run without idling
            calm <= (p == 2) || (p == RANDOM_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
                push_sample(next_white());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pcm_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
